### design/wcm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and tables of the wavetable channel mixer.
package wcm_pkg;

  localparam int NUM_CHANNELS    = 16;
  localparam int NUM_INSTRUMENTS = 8;
  localparam int WAVE_DEPTH      = 64;

  localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int INS_W    = 3;
  localparam int IDX_W    = 6;
  localparam int LEN_W    = 7;
  localparam int PHASE_W  = 16;
  localparam int VOL_W    = 7;
  localparam int STEP_W   = 13;
  localparam int SAMPLE_W = 16;
  localparam int NOTE_W   = 7;
  localparam int PER_W    = 15;

  localparam int RAMP_LEN       = 64;
  localparam int MAX_NOTE       = 84;
  localparam int STEP_NUMERATOR = 474400;

  localparam int DIV_NUM_W = 19;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam int WAVE_ADDR_W = INS_W + IDX_W;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [VOL_W-1:0]   vol;
    logic [STEP_W-1:0]  step;
    logic [INS_W-1:0]   ins;
    logic               gate;
  } chan_entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  // Ten times the semitone period.
  function automatic logic [PER_W-1:0] period_x10(input logic [3:0] semi);
    logic [PER_W-1:0] p;
    case (semi)
      4'd0:    p = 15'd10240;
      4'd1:    p = 15'd10850;
      4'd2:    p = 15'd11490;
      4'd3:    p = 15'd12180;
      4'd4:    p = 15'd12900;
      4'd5:    p = 15'd13670;
      4'd6:    p = 15'd14480;
      4'd7:    p = 15'd15340;
      4'd8:    p = 15'd16250;
      4'd9:    p = 15'd17220;
      4'd10:   p = 15'd18250;
      4'd11:   p = 15'd19330;
      default: p = 15'd10240;
    endcase
    return p;
  endfunction

  // Period for a note: octave from seven threshold compares, semitone from the remainder.
  function automatic logic [PER_W-1:0] note_period(input logic [NOTE_W-1:0] note);
    logic [NOTE_W-1:0] ns;
    logic [2:0]        oct;
    logic [NOTE_W-1:0] semi;
    ns  = (note > NOTE_W'(MAX_NOTE)) ? NOTE_W'(MAX_NOTE) : note;
    oct = '0;
    for (int j = 0; j < 7; j++) begin
      if (ns > NOTE_W'(12 * j)) oct = oct + 3'd1;
    end
    semi = NOTE_W'(12 * oct) - ns;
    return period_x10(semi[3:0]) >> (3'd7 - oct);
  endfunction

  // Power-up waveform of instrument 0.
  function automatic logic [SAMPLE_W-1:0] ramp_word(input logic [IDX_W-1:0] idx);
    logic [SAMPLE_W-1:0] w;
    w = SAMPLE_W'({idx, 3'b000});
    if (idx == IDX_W'(31)) w = SAMPLE_W'(255);
    else if (idx == IDX_W'(32)) w = '0;
    else if (idx > IDX_W'(32)) w = w - SAMPLE_W'(512);
    return w;
  endfunction

endpackage

### design/wcm_div.sv
`timescale 1ns / 1ps
// Shared restoring divider: one quotient bit per cycle.
module wcm_div import wcm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_NUM_W-1:0] num;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic                 done;

  logic [DIV_DEN_W:0] shifted;
  logic [DIV_DEN_W:0] trial;

  assign shifted = {rem, num[DIV_NUM_W-1]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIV_NUM_W);
        num   <= req.num;
        den   <= req.den;
        rem   <= '0;
        quo   <= '0;
      end else if (busy) begin
        num <= {num[DIV_NUM_W-2:0], 1'b0};
        if (!trial[DIV_DEN_W]) begin
          rem <= trial[DIV_DEN_W-1:0];
          quo <= {quo[DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DIV_DEN_W-1:0];
          quo <= {quo[DIV_NUM_W-2:0], 1'b0};
        end
        count <= count - DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

### design/wcm_chan_mem.sv
`timescale 1ns / 1ps
// Per-channel state memory with registered read and per-entry valid bits.
module wcm_chan_mem import wcm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [CH_W-1:0] rd_addr,
  input  logic            wr_en,
  input  logic [CH_W-1:0] wr_addr,
  input  chan_entry_t     wr_data,
  output chan_entry_t     rd_data
);

  chan_entry_t             mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] valid;
  chan_entry_t             rd_q;
  logic                    rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) valid[wr_addr] <= 1'b1;
      if (rd_en) rd_valid <= valid[rd_addr];
    end
  end

  // Unwritten entries read as the reset value.
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

### design/wcm_wave_mem.sv
`timescale 1ns / 1ps
// Instrument waveform memory; instrument 0 reads the ramp at each index until that word is written.
module wcm_wave_mem import wcm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [INS_W-1:0]    rd_ins,
  input  logic [IDX_W-1:0]    rd_idx,
  input  logic                wr_en,
  input  logic [INS_W-1:0]    wr_ins,
  input  logic [IDX_W-1:0]    wr_idx,
  input  logic [SAMPLE_W-1:0] wr_data,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0]   mem [2**WAVE_ADDR_W];
  logic [WAVE_DEPTH-1:0] written0;
  logic [SAMPLE_W-1:0]   rd_q;
  logic [SAMPLE_W-1:0]   ramp_q;
  logic                  use_ramp;

  always_ff @(posedge clk) begin
    if (wr_en) mem[{wr_ins, wr_idx}] <= wr_data;
    if (rd_en) begin
      rd_q   <= mem[{rd_ins, rd_idx}];
      ramp_q <= ramp_word(rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written0 <= '0;
      use_ramp <= 1'b0;
    end else begin
      if (wr_en && wr_ins == '0) written0[wr_idx] <= 1'b1;
      if (rd_en) use_ramp <= (rd_ins == '0) && !written0[rd_idx];
    end
  end

  assign rd_data = use_ramp ? ramp_q : rd_q;

endmodule

### design/wavetable_channel_mixer_unit.sv
`timescale 1ns / 1ps
// Top level of the wavetable channel mixer: item sequencer and mixing datapath.
//
// Input channel (in_valid / in_stall) carries one item per beat: a sample tick,
// a set-channel command, a wave word write or a wave length write. Output
// channel (out_valid / out_stall) carries one mixed_sample beat per tick.
// Items are taken one at a time; in_stall is high while an item is in work.
// Wave and length writes are taken without leaving the idle state. A set-channel
// item waits in S_SET for the phase step from the shared bit-serial divider.
// A tick walks all channels through the channel memory: a silent channel only
// passes S_CH, a sounding one S_CH, S_CUR, S_NXT, S_MUL1 and S_MUL2 (two wave
// memory reads, two multiplies), plus S_NDIV or S_PDIV whenever a wrap index or
// phase needs a full modulo from the divider; the tick finishes in S_DONE.
// The result sits in an output register, so the next item is taken while it
// waits; a tick that finishes while the previous sample is still stalled holds
// until that beat leaves. Reset (rst, synchronous) clears the channel state,
// makes instrument 0 the 64-word ramp with length 64 and all others length 0,
// and drops any pending output beat. No clearing pass is needed.
module wavetable_channel_mixer_unit import wcm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 kind,
  input  logic [3:0]                 channel_index,
  input  logic [NOTE_W-1:0]          note,
  input  logic [VOL_W-1:0]           volume,
  input  logic                       gate,
  input  logic [INS_W-1:0]           instrument_index,
  input  logic [IDX_W-1:0]           wave_index,
  input  logic signed [SAMPLE_W-1:0] wave_value,
  input  logic [LEN_W-1:0]           wave_length,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] mixed_sample
);

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_WAVE = 2'd2;
  localparam logic [1:0] KIND_LEN  = 2'd3;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SET  = 4'd1;
  localparam logic [3:0] S_CH   = 4'd2;
  localparam logic [3:0] S_NDIV = 4'd3;
  localparam logic [3:0] S_CUR  = 4'd4;
  localparam logic [3:0] S_NXT  = 4'd5;
  localparam logic [3:0] S_MUL1 = 4'd6;
  localparam logic [3:0] S_MUL2 = 4'd7;
  localparam logic [3:0] S_PDIV = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam int Q_W     = PHASE_W + 1;

  logic [3:0] state;
  logic [3:0] state_next;

  logic accept;
  logic out_free;
  logic ch_ok;

  // channel memory ports
  logic        ch_rd_en;
  logic [CH_W-1:0] ch_rd_addr;
  logic        ch_wr_en;
  chan_entry_t ch_wr_data;
  chan_entry_t ent;

  // wave memory ports
  logic                wv_rd_en;
  logic [IDX_W-1:0]    wv_rd_idx;
  logic                wv_wr_en;
  logic [SAMPLE_W-1:0] wave_rd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CH_W-1:0]     cidx;
  logic                last_ch;
  logic                advance;
  logic [VOL_W-1:0]    set_vol;
  logic                set_gate;
  logic [INS_W-1:0]    set_ins;
  logic [LEN_W-1:0]    len_reg [NUM_INSTRUMENTS];
  logic [IDX_W-1:0]    nxt_r;
  logic [SAMPLE_W-1:0] cur_r;
  logic signed [25:0]  prod1;
  logic signed [24:0]  prod2;
  logic [SAMPLE_W-1:0] sum;
  logic [SAMPLE_W-1:0] out_q;

  // per-channel datapath
  logic               ins_ok;
  logic [LEN_W-1:0]   size;
  logic               active;
  logic [IDX_W-1:0]   pos;
  logic [LEN_W-1:0]   pos1;
  logic [LEN_W-1:0]   pos1_m;
  logic               nxt_fast_ok;
  logic [IDX_W-1:0]   nxt_fast;
  logic [Q_W-1:0]     q;
  logic [Q_W-1:0]     lwrap;
  logic [Q_W-1:0]     q_m;
  logic               ph_fast_ok;
  logic [PHASE_W-1:0] ph_fast;
  logic signed [16:0] cur17;
  logic signed [16:0] diff;
  logic signed [25:0] p1s;
  logic signed [16:0] interp;
  logic signed [24:0] p2s;
  logic [LEN_W-1:0]   len_clip;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign ch_ok    = 32'(channel_index) < NUM_CHANNELS;
  assign last_ch  = (cidx == CH_W'(NUM_CHANNELS - 1));

  assign len_clip = (wave_length > LEN_W'(WAVE_DEPTH)) ? LEN_W'(WAVE_DEPTH) : wave_length;

  assign ins_ok = 32'(ent.ins) < NUM_INSTRUMENTS;
  assign size   = ins_ok ? len_reg[ent.ins] : '0;
  assign active = (ent.vol != '0) && ent.gate && (size != '0);

  assign pos = (ent.phase[PHASE_W-1:8] > 8'(WAVE_DEPTH - 1)) ? IDX_W'(WAVE_DEPTH - 1)
                                                            : ent.phase[8 +: IDX_W];
  assign pos1   = LEN_W'(pos) + LEN_W'(1);
  assign pos1_m = pos1 - size;
  assign nxt_fast_ok = (pos1 < size) || (pos1_m < size);
  assign nxt_fast    = (pos1 < size) ? pos1[IDX_W-1:0] : pos1_m[IDX_W-1:0];

  assign q          = {1'b0, ent.phase} + Q_W'(ent.step);
  assign lwrap      = Q_W'({size, 8'b0});
  assign q_m        = q - lwrap;
  assign ph_fast_ok = (q < lwrap) || (q_m < lwrap);
  assign ph_fast    = (q < lwrap) ? q[PHASE_W-1:0] : q_m[PHASE_W-1:0];

  assign cur17  = $signed({cur_r[SAMPLE_W-1], cur_r});
  assign diff   = $signed({wave_rd[SAMPLE_W-1], wave_rd}) - cur17;
  assign p1s    = prod1 >>> 8;
  assign interp = cur17 + $signed(p1s[16:0]);
  assign p2s    = prod2 >>> 4;

  always_comb begin
    state_next = state;
    ch_rd_en   = 1'b0;
    ch_rd_addr = cidx + CH_W'(1);
    ch_wr_en   = 1'b0;
    ch_wr_data = ent;
    wv_rd_en   = 1'b0;
    wv_rd_idx  = pos;
    wv_wr_en   = 1'b0;
    div_req    = '0;
    advance    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_TICK: begin
              ch_rd_en   = 1'b1;
              ch_rd_addr = '0;
              state_next = S_CH;
            end
            KIND_SET: begin
              if (ch_ok) begin
                ch_rd_en      = 1'b1;
                ch_rd_addr    = CH_W'(channel_index);
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(STEP_NUMERATOR);
                div_req.den   = DIV_DEN_W'(note_period(note));
                state_next    = S_SET;
              end
            end
            KIND_WAVE: begin
              wv_wr_en = (32'(instrument_index) < NUM_INSTRUMENTS)
                      && (32'(wave_index) < WAVE_DEPTH);
            end
            KIND_LEN: ;
            default: ;
          endcase
        end
      end
      S_SET: begin
        if (div_rsp.done) begin
          ch_wr_en        = 1'b1;
          ch_wr_data.vol  = set_vol;
          ch_wr_data.gate = set_gate;
          ch_wr_data.ins  = set_ins;
          ch_wr_data.step = div_rsp.quo[STEP_W-1:0];
          state_next      = S_IDLE;
        end
      end
      S_CH: begin
        if (!active) begin
          advance = 1'b1;
        end else if (nxt_fast_ok) begin
          wv_rd_en   = 1'b1;
          state_next = S_CUR;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(pos1);
          div_req.den   = DIV_DEN_W'(size);
          state_next    = S_NDIV;
        end
      end
      S_NDIV: begin
        if (div_rsp.done) begin
          wv_rd_en   = 1'b1;
          state_next = S_CUR;
        end
      end
      S_CUR: begin
        wv_rd_en   = 1'b1;
        wv_rd_idx  = nxt_r;
        state_next = S_NXT;
      end
      S_NXT:  state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: begin
        if (ph_fast_ok) begin
          ch_wr_en         = 1'b1;
          ch_wr_data.phase = ph_fast;
          advance          = 1'b1;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(q);
          div_req.den   = DIV_DEN_W'(lwrap);
          state_next    = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_rsp.done) begin
          ch_wr_en         = 1'b1;
          ch_wr_data.phase = div_rsp.rem[PHASE_W-1:0];
          advance          = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // move on to the next channel, or finish the tick
    if (advance) begin
      if (last_ch) begin
        state_next = S_DONE;
      end else begin
        ch_rd_en   = 1'b1;
        state_next = S_CH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_INSTRUMENTS; i++) begin
        len_reg[i] <= (i == 0) ? LEN_W'((RAMP_LEN < WAVE_DEPTH) ? RAMP_LEN : WAVE_DEPTH)
                               : '0;
      end
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (accept && kind == KIND_LEN && 32'(instrument_index) < NUM_INSTRUMENTS) begin
        len_reg[instrument_index] <= len_clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_TICK) begin
      cidx <= '0;
      sum  <= '0;
    end
    if (accept && kind == KIND_SET) begin
      cidx     <= CH_W'(channel_index);
      set_vol  <= volume;
      set_gate <= gate;
      set_ins  <= instrument_index;
    end
    if (advance && !last_ch) cidx <= cidx + CH_W'(1);
    if (state == S_CH && nxt_fast_ok) nxt_r <= nxt_fast;
    if (state == S_NDIV && div_rsp.done) nxt_r <= div_rsp.rem[IDX_W-1:0];
    if (state == S_CUR) cur_r <= wave_rd;
    if (state == S_NXT) prod1 <= diff * $signed({1'b0, ent.phase[7:0]});
    if (state == S_MUL1) prod2 <= interp * $signed({1'b0, ent.vol});
    if (state == S_MUL2) sum <= sum + p2s[SAMPLE_W-1:0];
    if (state == S_DONE && out_free) out_q <= sum;
  end

  assign mixed_sample = $signed(out_q);

  wcm_chan_mem u_chan_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (ch_rd_en),
    .rd_addr (ch_rd_addr),
    .wr_en   (ch_wr_en),
    .wr_addr (cidx),
    .wr_data (ch_wr_data),
    .rd_data (ent)
  );

  wcm_wave_mem u_wave_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (wv_rd_en),
    .rd_ins  (ent.ins),
    .rd_idx  (wv_rd_idx),
    .wr_en   (wv_wr_en),
    .wr_ins  (instrument_index),
    .wr_idx  (wave_index),
    .wr_data (wave_value),
    .rd_data (wave_rd)
  );

  wcm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

### test/wavetable_channel_mixer_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the wavetable channel mixer unit, with its own mix predictor.
module wavetable_channel_mixer_unit_test;
  import wcm_pkg::*;

  typedef enum logic [1:0] {
    KIND_TICK        = 2'd0,
    KIND_SET_CHANNEL = 2'd1,
    KIND_WAVE_WORD   = 2'd2,
    KIND_WAVE_LENGTH = 2'd3
  } mix_kind_t;

  typedef struct packed {
    mix_kind_t            kind;
    logic [3:0]           chan;
    logic [NOTE_W-1:0]    note;
    logic [VOL_W-1:0]     vol;
    logic                 gate;
    logic [INS_W-1:0]     ins;
    logic [IDX_W-1:0]     idx;
    logic [SAMPLE_W-1:0]  value;
    logic [LEN_W-1:0]     len;
  } mix_item_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 kind = '0;
  logic [3:0]                 channel_index = '0;
  logic [NOTE_W-1:0]          note = '0;
  logic [VOL_W-1:0]           volume = '0;
  logic                       gate = 1'b0;
  logic [INS_W-1:0]           instrument_index = '0;
  logic [IDX_W-1:0]           wave_index = '0;
  logic signed [SAMPLE_W-1:0] wave_value = '0;
  logic [LEN_W-1:0]           wave_length = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] mixed_sample;

  wavetable_channel_mixer_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .channel_index(channel_index), .note(note), .volume(volume),
    .gate(gate), .instrument_index(instrument_index), .wave_index(wave_index),
    .wave_value(wave_value), .wave_length(wave_length),
    .out_valid(out_valid), .out_stall(out_stall), .mixed_sample(mixed_sample)
  );

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Mixer state as the predictor sees it.
  int phase_mem [NUM_CHANNELS];
  int vol_mem   [NUM_CHANNELS];
  int step_mem  [NUM_CHANNELS];
  int ins_mem   [NUM_CHANNELS];
  int gate_mem  [NUM_CHANNELS];
  int wave_mem  [NUM_INSTRUMENTS][WAVE_DEPTH];
  int len_mem   [NUM_INSTRUMENTS];

  logic [SAMPLE_W-1:0] sample_queue [$];
  logic [SAMPLE_W-1:0] want_sample;

  int error_count = 0;
  int items_sent = 0;
  int samples_checked = 0;
  bit src_idling = 1'b0;
  bit sink_idling = 1'b0;
  int hold_left = 0;
  int burst_left = 0;

  function automatic int semi_period(input int s);
    case (s)
      0:       return 1024;
      1:       return 1085;
      2:       return 1149;
      3:       return 1218;
      4:       return 1290;
      5:       return 1367;
      6:       return 1448;
      7:       return 1534;
      8:       return 1625;
      9:       return 1722;
      10:      return 1825;
      default: return 1933;
    endcase
  endfunction

  function automatic int note_step(input int nt);
    int n;
    int per;
    if (nt > MAX_NOTE) nt = MAX_NOTE;
    n = 120 - nt;
    per = (10 * semi_period(n % 12)) >> (n / 12 - 3);
    if (per == 0) return 0;
    return (STEP_NUMERATOR / per) & 'h1FFF;
  endfunction

  task automatic reset_mix_state();
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      phase_mem[c] = 0;
      vol_mem[c] = 0;
      step_mem[c] = 0;
      ins_mem[c] = 0;
      gate_mem[c] = 0;
    end
    for (int k = 0; k < NUM_INSTRUMENTS; k++) begin
      len_mem[k] = 0;
      for (int i = 0; i < WAVE_DEPTH; i++) wave_mem[k][i] = 0;
    end
    // Instrument 0 powers up as a ramp with its peak of 255 at word 31 and zero at word 32.
    for (int i = 0; i < RAMP_LEN; i++) begin
      if (i == 31) wave_mem[0][i] = 255;
      else if (i == 32) wave_mem[0][i] = 0;
      else if (i < 31) wave_mem[0][i] = i * 8;
      else wave_mem[0][i] = i * 8 - 512;
    end
    len_mem[0] = RAMP_LEN;
  endtask

  task automatic apply_item(input mix_item_t it);
    int sum;
    int size;
    int p;
    int pos;
    int nxt;
    int cur;
    int b;
    int ci;
    case (it.kind)
      KIND_SET_CHANNEL: begin
        vol_mem[it.chan]  = int'(it.vol);
        gate_mem[it.chan] = int'(it.gate);
        ins_mem[it.chan]  = int'(it.ins);
        step_mem[it.chan] = note_step(int'(it.note));
      end
      KIND_WAVE_WORD: begin
        wave_mem[it.ins][it.idx] = int'($signed(it.value));
      end
      KIND_WAVE_LENGTH: begin
        len_mem[it.ins] = (int'(it.len) > WAVE_DEPTH) ? WAVE_DEPTH : int'(it.len);
      end
      default: begin
        sum = 0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          ci = ins_mem[c];
          size = len_mem[ci];
          if (vol_mem[c] != 0 && gate_mem[c] != 0 && size != 0) begin
            p = phase_mem[c];
            pos = p >> 8;
            if (pos >= WAVE_DEPTH) pos = WAVE_DEPTH - 1;
            nxt = (pos + 1) % size;
            cur = wave_mem[ci][pos];
            b = cur + (((wave_mem[ci][nxt] - cur) * (p & 255)) >>> 8);
            sum = sum + ((b * vol_mem[c]) >>> 4);
            phase_mem[c] = (p + step_mem[c]) % (size << 8);
          end
        end
        sample_queue.push_back(SAMPLE_W'(sum));
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    $display("MISMATCH at %0t: %s, got %0d, expected %0d", $realtime, what,
             $signed(got), $signed(want));
    error_count++;
  endtask

  // Check each sample beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (sample_queue.size() == 0) begin
        report_mismatch("sample with no tick pending", mixed_sample, '0);
      end else begin
        want_sample = sample_queue.pop_front();
        samples_checked++;
        if (mixed_sample !== want_sample)
          report_mismatch("mixed_sample", mixed_sample, want_sample);
      end
    end
  end

  // Receiver: random stall bursts while sink_idling is set, and a long hold (taking priority) while hold_left runs.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (sink_idling && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        burst_left = int'($urandom_range(0, 15));
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic idle_for(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic push_item(input mix_item_t it);
    if (src_idling && $urandom_range(0, 5) == 0) idle_for(int'($urandom_range(1, 16)));
    @(negedge clk);
    kind             <= it.kind;
    channel_index    <= it.chan;
    note             <= it.note;
    volume           <= it.vol;
    gate             <= it.gate;
    instrument_index <= it.ins;
    wave_index       <= it.idx;
    wave_value       <= it.value;
    wave_length      <= it.len;
    in_valid         <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_item(it);
    items_sent++;
  endtask

  // Every field but kind random (kind defaults to a tick); callers overwrite the ones that matter.
  function automatic mix_item_t random_fields();
    mix_item_t it;
    it.kind  = KIND_TICK;
    it.chan  = 4'($urandom_range(0, 15));
    it.note  = NOTE_W'(($urandom_range(0, 15) == 0) ? $urandom_range(85, 127)
                                                    : $urandom_range(0, 84));
    it.vol   = VOL_W'($urandom_range(0, 127));
    it.gate  = 1'($urandom_range(0, 1));
    it.ins   = INS_W'($urandom_range(0, NUM_INSTRUMENTS - 1));
    it.idx   = IDX_W'($urandom_range(0, WAVE_DEPTH - 1));
    it.value = SAMPLE_W'($urandom_range(0, 65535));
    it.len   = LEN_W'(($urandom_range(0, 15) == 0) ? $urandom_range(65, 127)
                                                   : $urandom_range(0, 64));
    return it;
  endfunction

  task automatic send_tick();
    mix_item_t it;
    it = random_fields();
    it.kind = KIND_TICK;
    push_item(it);
  endtask

  task automatic send_set_channel(input int ch, input int nt, input int vl, input int gt,
                                  input int ins);
    mix_item_t it;
    it = random_fields();
    it.kind = KIND_SET_CHANNEL;
    it.chan = 4'(ch);
    it.note = NOTE_W'(nt);
    it.vol  = VOL_W'(vl);
    it.gate = 1'(gt);
    it.ins  = INS_W'(ins);
    push_item(it);
  endtask

  task automatic send_wave_word(input int ins, input int idx, input int val);
    mix_item_t it;
    it = random_fields();
    it.kind  = KIND_WAVE_WORD;
    it.ins   = INS_W'(ins);
    it.idx   = IDX_W'(idx);
    it.value = SAMPLE_W'(val);
    push_item(it);
  endtask

  task automatic send_wave_length(input int ins, input int len);
    mix_item_t it;
    it = random_fields();
    it.kind = KIND_WAVE_LENGTH;
    it.ins  = INS_W'(ins);
    it.len  = LEN_W'(len);
    push_item(it);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sample_queue.size() != 0) @(posedge clk);
  endtask

  // Only instrument 0 is readable here; the others keep length zero.
  task automatic test_directed();
    src_idling = 1'b0;
    sink_idling = 1'b0;
    send_tick();
    send_set_channel(0, 0, 127, 1, 0);
    send_tick();
    send_tick();
    send_set_channel(15, 84, 127, 1, 0);
    send_set_channel(1, 127, 1, 1, 0);
    send_set_channel(2, 50, 0, 1, 0);
    send_set_channel(3, 60, 100, 0, 0);
    send_set_channel(4, 30, 127, 1, 5);
    send_tick();
    send_tick();
    send_wave_word(0, 63, -32768);
    send_wave_word(0, 0, 32767);
    send_tick();
    // Shorten under a running phase, then saturate the length back up.
    send_wave_length(0, 5);
    send_tick();
    send_tick();
    send_wave_length(0, 127);
    send_wave_length(6, 0);
    send_tick();
    // New note keeps the phase.
    send_set_channel(0, 40, 127, 1, 0);
    send_tick();
    wait_drained();
  endtask

  task automatic test_fill_instruments();
    src_idling = 1'b1;
    sink_idling = 1'b1;
    for (int k = 1; k < NUM_INSTRUMENTS; k++)
      for (int i = 0; i < WAVE_DEPTH; i++)
        send_wave_word(k, i, int'($urandom_range(0, 65535)));
  endtask

  task automatic test_random_mix(input int count);
    mix_item_t it;
    int r;
    for (int i = 0; i < count; i++) begin
      // Stretch without source idles or receiver stalls in the middle of the run.
      src_idling = !(i >= count / 3 && i < count / 3 + 70);
      sink_idling = src_idling;
      it = random_fields();
      r = int'($urandom_range(0, 99));
      if (r < 48) it.kind = KIND_TICK;
      else if (r < 78) begin
        it.kind = KIND_SET_CHANNEL;
        if ($urandom_range(0, 3) != 0) it.gate = 1'b1;
      end else if (r < 90) it.kind = KIND_WAVE_WORD;
      else it.kind = KIND_WAVE_LENGTH;
      push_item(it);
    end
  endtask

  task automatic test_output_hold();
    src_idling = 1'b0;
    sink_idling = 1'b0;
    wait_drained();
    hold_left = 1500;
    for (int i = 0; i < 8; i++) begin
      send_tick();
      if (i == 3) send_set_channel(int'($urandom_range(0, 15)), int'($urandom_range(0, 84)),
                                   127, 1, int'($urandom_range(0, NUM_INSTRUMENTS - 1)));
    end
    // Pause the sender until every sample is out.
    wait_drained();
    send_tick();
    send_tick();
  endtask

  task automatic test_final_stream(input int count);
    mix_item_t it;
    src_idling = 1'b0;
    sink_idling = 1'b0;
    for (int i = 0; i < count; i++) begin
      it = random_fields();
      if ($urandom_range(0, 2) != 0) it.kind = KIND_TICK;
      else begin
        it.kind = KIND_SET_CHANNEL;
        it.gate = 1'b1;
      end
      push_item(it);
    end
  endtask

  initial begin
    reset_mix_state();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_instruments();
    test_random_mix(460);
    test_output_hold();
    test_final_stream(120);
    wait_drained();
    repeat (800) @(posedge clk);
    $display("Sent %0d input beats, checked %0d mixed samples.", items_sent, samples_checked);
    $display("Covered note and length extremes, wrap-around, all instruments, long output hold.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
